// ===== rtl/core/pctcc_pkg.sv =====
// Package for the point transform, crop and colorize core.
// Holds field widths, register indexes, the shared body_t struct and helper functions.
// No dependencies.
`default_nettype none
package pctcc_pkg;

  localparam int COORD_BITS = 24;
  localparam int COEF_BITS  = 18;
  localparam int COEF_FRAC  = COEF_BITS - 2;
  localparam int OFF_BITS   = 20;
  localparam int ROW_BITS   = 3 * COEF_BITS;
  localparam int OFFV_BITS  = 3 * OFF_BITS;
  localparam int CFG_DW     = 60;
  localparam int CFG_AW     = 3;
  localparam int COLOR_BITS = 24;
  // product of coordinate and coefficient, and a three-term sum with offset
  localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = 2;

  localparam logic [CFG_AW-1:0] REG_EXTR_ROW0 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_EXTR_ROW1 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_EXTR_ROW2 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_EXTR_OFF  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ODOM_ROW0 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ODOM_ROW1 = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ODOM_ROW2 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_ODOM_EN   = 3'd7;

  localparam logic [ROW_BITS-1:0] ROW0_RST = ROW_BITS'(1) << COEF_FRAC;
  localparam logic [ROW_BITS-1:0] ROW1_RST = ROW_BITS'(1) << (COEF_FRAC + COEF_BITS);
  localparam logic [ROW_BITS-1:0] ROW2_RST = ROW_BITS'(1) << (COEF_FRAC + 2 * COEF_BITS);

  localparam logic signed [COORD_BITS-1:0] CROP_LIM = COORD_BITS'(3 * 4096);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ROW_BITS-1:0] row_t;

  // body-frame point handed from the front part to the back part
  typedef struct packed {
    coord_t bx;
    coord_t by;
    coord_t bz;
    logic   keep;
    logic   last;
  } body_t;

  // round half up at COEF_FRAC and saturate to the coordinate range
  function automatic coord_t round_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] r;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    r  = (acc + (ACC_BITS'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    hi = ACC_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    lo = -hi - ACC_BITS'(1);
    if (r > hi) return coord_t'(hi);
    else if (r < lo) return coord_t'(lo);
    else return coord_t'(r);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] coef(input row_t row, input int j);
    return row[COEF_BITS*j +: COEF_BITS];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pctcc_front.sv =====
// Front part: extrinsic transform, saturation and crop test.
// Two register stages (products, then sum/round/compare). Uses pctcc_pkg.
`default_nettype none
module pctcc_front import pctcc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_en,
  input  wire coord_t px,
  input  wire coord_t py,
  input  wire coord_t pz,
  input  wire logic   plast,
  input  wire row_t   row0,
  input  wire row_t   row1,
  input  wire row_t   row2,
  input  wire logic [OFFV_BITS-1:0] offs,
  output logic        out_v,
  output body_t       body
);

  logic signed [PROD_BITS-1:0] prod_r [9];
  logic signed [OFF_BITS-1:0]  off_r [3];
  logic                        last_r;
  logic                        v1_r;
  body_t                       body_r;
  logic                        v2_r;
  row_t                        rows [3];
  coord_t                      pts [3];
  coord_t                      bsum [3];
  logic                        keep_c;

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;
  assign pts[0]  = px;
  assign pts[1]  = py;
  assign pts[2]  = pz;

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (in_en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[3*i+j] <= PROD_BITS'(coef(rows[i], j)) * PROD_BITS'(pts[j]);
        end
        off_r[i] <= offs[OFF_BITS*i +: OFF_BITS];
      end
      last_r <= plast;
    end
  end

  // sum, round and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsum[i] = round_sat((ACC_BITS'(off_r[i]) <<< COEF_FRAC)
                + ACC_BITS'(prod_r[3*i]) + ACC_BITS'(prod_r[3*i+1])
                + ACC_BITS'(prod_r[3*i+2]));
    end
    keep_c = (bsum[0] > -CROP_LIM) && (bsum[0] < CROP_LIM)
          && (bsum[1] > -CROP_LIM) && (bsum[1] < CROP_LIM)
          && ((COORD_BITS + 4)'(bsum[2]) * 10 > -(COORD_BITS + 4)'(4096));
  end

  // stage 2: body point and keep flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      body_r.bx   <= bsum[0];
      body_r.by   <= bsum[1];
      body_r.bz   <= bsum[2];
      body_r.keep <= keep_c;
      body_r.last <= last_r;
    end
  end

  assign out_v = v2_r;
  assign body  = body_r;

endmodule
`default_nettype wire

// ===== rtl/core/pctcc_queue.sv =====
// Short FIFO between front and back parts.
// Carries body_t entries. Uses pctcc_pkg.
`default_nettype none
module pctcc_queue import pctcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  wire body_t wr_data,
  input  wire logic  rd_en,
  output body_t      rd_data,
  output logic       not_empty,
  output logic [QPTR_BITS:0] count
);

  body_t                mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wp_r;
  logic [QPTR_BITS-1:0] rp_r;
  logic [QPTR_BITS:0]   cnt_r;

  // write entries
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_BITS + 1)'(wr_en) - (QPTR_BITS + 1)'(rd_en);
    end
  end

  assign rd_data   = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/pctcc_back.sv =====
// Back part: jet color and odometry rotation for one body point.
// Three stages; advances on a free enable. Uses pctcc_pkg.
`default_nettype none
module pctcc_back import pctcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire logic  in_v,
  input  wire body_t body,
  input  wire row_t  row0,
  input  wire row_t  row1,
  input  wire row_t  row2,
  input  wire logic  odom_en,
  output logic       out_v,
  output body_t      out_body,
  output logic [COLOR_BITS-1:0] out_color,
  output logic       out_odom_valid,
  output coord_t     out_ox,
  output coord_t     out_oy,
  output coord_t     out_oz
);

  localparam int NUM_BITS = 17;
  localparam int SCL_BITS = 28;
  localparam logic [NUM_BITS-1:0] DEN = NUM_BITS'(45056);
  // segment bounds on 4*num
  localparam logic [NUM_BITS+2:0] DEN_X1 = (NUM_BITS + 3)'(45056);
  localparam logic [NUM_BITS+2:0] DEN_X2 = (NUM_BITS + 3)'(2 * 45056);
  localparam logic [NUM_BITS+2:0] DEN_X3 = (NUM_BITS + 3)'(3 * 45056);
  localparam logic [NUM_BITS+2:0] DEN_X4 = (NUM_BITS + 3)'(4 * 45056);

  // stage 1 registers
  logic                        v1_r;
  body_t                       b1_r;
  logic                        en1_r;
  logic signed [PROD_BITS-1:0] prod_r [9];
  logic [1:0]                  seg_r;
  logic [SCL_BITS-1:0]         scl_r;
  // stage 2 registers
  logic                        v2_r;
  body_t                       b2_r;
  logic                        en2_r;
  coord_t                      o_r [3];
  logic [1:0]                  seg2_r;
  logic [SCL_BITS-1:0]         q_r;
  // stage 3 output registers
  logic                        v3_r;
  body_t                       b3_r;
  logic                        en3_r;
  coord_t                      o3_r [3];
  logic [COLOR_BITS-1:0]       col_r;

  row_t                        rows [3];
  coord_t                      bp [3];
  logic signed [COORD_BITS+4:0] num_s;
  logic [NUM_BITS-1:0]         num_c;
  logic [NUM_BITS+2:0]         n4;
  logic [NUM_BITS+2:0]         frac;
  logic [1:0]                  seg_c;
  logic [7:0]                  ch;
  logic [SCL_BITS-1:0]         qv;

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;
  assign bp[0]   = body.bx;
  assign bp[1]   = body.by;
  assign bp[2]   = body.bz;

  // clamp height into the color range and pick the segment
  always_comb begin
    num_s = (COORD_BITS + 5)'(body.bz) * (COORD_BITS + 5)'(10)
          + (COORD_BITS + 5)'(16384);
    if (num_s < 0) num_c = '0;
    else if (num_s > (COORD_BITS + 5)'(DEN)) num_c = DEN;
    else num_c = NUM_BITS'(num_s);
    n4 = (NUM_BITS + 3)'(num_c) << 2;
    if (n4 < DEN_X1) begin
      seg_c = 2'd0; frac = n4;
    end else if (n4 < DEN_X2) begin
      seg_c = 2'd1; frac = DEN_X2 - n4;
    end else if (n4 < DEN_X3) begin
      seg_c = 2'd2; frac = n4 - DEN_X2;
    end else begin
      seg_c = 2'd3; frac = DEN_X4 - n4;
    end
  end

  // quotient 255*frac/DEN with frac <= DEN: reciprocal multiply and fix-up
  localparam int RSH = 32;
  localparam logic [RSH:0] RECIP = (RSH + 1)'(((64'd1 << RSH) + 64'd45055) / 64'd45056);
  always_comb begin
    logic [63:0] prodq;
    logic [SCL_BITS-1:0] qq;
    prodq = 64'(scl_r) * 64'(RECIP);
    qq = SCL_BITS'(prodq >> RSH);
    if (64'(qq) * 64'(DEN) > 64'(scl_r)) qq = qq - 1'b1;
    qv = qq;
  end

  always_comb begin
    ch = q_r[7:0];
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r  <= body;
      en1_r <= odom_en;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod_r[3*i+j] <= PROD_BITS'(coef(rows[i], j)) * PROD_BITS'(bp[j]);
      seg_r <= seg_c;
      scl_r <= SCL_BITS'(frac) * SCL_BITS'(255);

      b2_r   <= b1_r;
      en2_r  <= en1_r;
      seg2_r <= seg_r;
      q_r    <= qv;
      for (int i = 0; i < 3; i++)
        o_r[i] <= round_sat(ACC_BITS'(prod_r[3*i]) + ACC_BITS'(prod_r[3*i+1])
                            + ACC_BITS'(prod_r[3*i+2]));

      b3_r  <= b2_r;
      en3_r <= en2_r;
      for (int i = 0; i < 3; i++)
        o3_r[i] <= (b2_r.keep && en2_r) ? o_r[i] : '0;
      if (!b2_r.keep) col_r <= '0;
      else begin
        case (seg2_r)
          2'd0:    col_r <= {8'd0, ch, 8'd255};
          2'd1:    col_r <= {8'd0, 8'd255, ch};
          2'd2:    col_r <= {ch, 8'd255, 8'd0};
          2'd3:    col_r <= {8'd255, ch, 8'd0};
          default: col_r <= '0;
        endcase
      end
    end
  end

  assign out_v          = v3_r;
  assign out_body       = b3_r;
  assign out_color      = col_r;
  assign out_odom_valid = en3_r;
  assign out_ox         = o3_r[0];
  assign out_oy         = o3_r[1];
  assign out_oz         = o3_r[2];

endmodule
`default_nettype wire

// ===== rtl/core/point_cloud_transform_crop_colorize_core.sv =====
// Top level of the point transform, crop and colorize core.
// Instantiates pctcc_front, pctcc_queue and pctcc_back; uses pctcc_pkg.
`default_nettype none
// One lidar point per cycle in, one result per cycle out. A point is moved
// into the body frame by the extrinsic rotation and offset, cropped to the
// box |x|,|y| < 3 m, z > -0.1 m, colored by height and, when odometry is
// enabled, rotated into the odometry frame. Each point passes the front
// transform, then the queue, then the back pipeline; the front issues only
// while the four-entry queue has room for all points in flight, so the block
// sustains one point per cycle while out_ready is high.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while the block is empty.
module point_cloud_transform_crop_colorize_core import pctcc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic signed [COORD_BITS-1:0] in_z,
  input  wire logic                  in_last_point,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_keep,
  output logic signed [COORD_BITS-1:0] out_base_x,
  output logic signed [COORD_BITS-1:0] out_base_y,
  output logic signed [COORD_BITS-1:0] out_base_z,
  output logic [COLOR_BITS-1:0]      out_color,
  output logic                       out_odom_valid,
  output logic signed [COORD_BITS-1:0] out_odom_x,
  output logic signed [COORD_BITS-1:0] out_odom_y,
  output logic signed [COORD_BITS-1:0] out_odom_z,
  output logic                       out_end_of_cloud
);

  row_t                 extr_row0_r, extr_row1_r, extr_row2_r;
  row_t                 odom_row0_r, odom_row1_r, odom_row2_r;
  logic [OFFV_BITS-1:0] extr_off_r;
  logic                 odom_en_r;
  logic [1:0]           infl_r;
  logic [1:0]           infl_nxt;
  logic                 acc_in;
  logic                 f_v;
  body_t                f_body;
  body_t                q_data;
  logic                 q_ne;
  logic [QPTR_BITS:0]   q_cnt;
  logic                 adv;
  logic                 pop;
  logic                 bk_v;
  body_t                bk_body;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extr_row0_r <= ROW0_RST;
      extr_row1_r <= ROW1_RST;
      extr_row2_r <= ROW2_RST;
      extr_off_r  <= '0;
      odom_row0_r <= ROW0_RST;
      odom_row1_r <= ROW1_RST;
      odom_row2_r <= ROW2_RST;
      odom_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EXTR_ROW0: extr_row0_r <= cfg_wdata[ROW_BITS-1:0];
        REG_EXTR_ROW1: extr_row1_r <= cfg_wdata[ROW_BITS-1:0];
        REG_EXTR_ROW2: extr_row2_r <= cfg_wdata[ROW_BITS-1:0];
        REG_EXTR_OFF:  extr_off_r  <= cfg_wdata[OFFV_BITS-1:0];
        REG_ODOM_ROW0: odom_row0_r <= cfg_wdata[ROW_BITS-1:0];
        REG_ODOM_ROW1: odom_row1_r <= cfg_wdata[ROW_BITS-1:0];
        REG_ODOM_ROW2: odom_row2_r <= cfg_wdata[ROW_BITS-1:0];
        REG_ODOM_EN:   odom_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // back pipeline advances when its output slot is free or being taken
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_ne;

  // count points inside the front pipeline; issue only with queue room
  assign in_ready = ((QPTR_BITS + 1)'(q_cnt) + (QPTR_BITS + 1)'(infl_r))
                    < (QPTR_BITS + 1)'(QDEPTH);
  assign acc_in   = in_valid && in_ready;

  always_comb begin
    infl_nxt = infl_r + 2'(acc_in) - 2'(f_v);
  end

  // hold the number of points in the front stages, up to the queue write
  always_ff @(posedge clk) begin
    if (!rst_n) infl_r <= '0;
    else        infl_r <= infl_nxt;
  end

  pctcc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_en (acc_in),
    .px    (in_x),
    .py    (in_y),
    .pz    (in_z),
    .plast (in_last_point),
    .row0  (extr_row0_r),
    .row1  (extr_row1_r),
    .row2  (extr_row2_r),
    .offs  (extr_off_r),
    .out_v (f_v),
    .body  (f_body)
  );

  pctcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (f_v),
    .wr_data   (f_body),
    .rd_en     (pop),
    .rd_data   (q_data),
    .not_empty (q_ne),
    .count     (q_cnt)
  );

  pctcc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_v           (q_ne),
    .body           (q_data),
    .row0           (odom_row0_r),
    .row1           (odom_row1_r),
    .row2           (odom_row2_r),
    .odom_en        (odom_en_r),
    .out_v          (bk_v),
    .out_body       (bk_body),
    .out_color      (out_color),
    .out_odom_valid (out_odom_valid),
    .out_ox         (out_odom_x),
    .out_oy         (out_odom_y),
    .out_oz         (out_odom_z)
  );

  assign out_valid        = bk_v;
  assign out_keep         = bk_body.keep;
  assign out_base_x       = bk_body.bx;
  assign out_base_y       = bk_body.by;
  assign out_base_z       = bk_body.bz;
  assign out_end_of_cloud = bk_body.last;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for point_cloud_transform_crop_colorize_core.
// Predicts each result in-bench and compares every field; uses pctcc_pkg.
`timescale 1ns / 1ps

module tb_top;
  import pctcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam longint CROP_Q12   = 3 * 4096;

  typedef struct {
    logic             keep;
    coord_t           bx, by, bz;
    logic [23:0]      color;
    logic             odom_valid;
    coord_t           ox, oy, oz;
    logic             eoc;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_x = '0, in_y = '0, in_z = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_keep, out_odom_valid, out_end_of_cloud;
  coord_t out_base_x, out_base_y, out_base_z, out_odom_x, out_odom_y, out_odom_z;
  logic [COLOR_BITS-1:0] out_color;

  // shadow copy of the configuration registers
  row_t extr_row[3];
  row_t odom_row[3];
  logic [OFFV_BITS-1:0] extr_off;
  logic odom_en;

  point_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  point_cloud_transform_crop_colorize_core dut (.*);

  always #10 clk = ~clk;

  // randomly stall the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint coef_at(row_t row, int j);
    logic signed [COEF_BITS-1:0] c;
    c = row[COEF_BITS*j +: COEF_BITS];
    return c;
  endfunction

  // one matrix row: exact sum, round half up at Q16, saturate
  function automatic longint rotate_row(row_t row, longint p0, longint p1, longint p2,
                                        longint off);
    longint acc;
    longint hi;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    acc = off * 65536 + coef_at(row, 0) * p0 + coef_at(row, 1) * p1
          + coef_at(row, 2) * p2 + 32768;
    acc = acc >>> COEF_FRAC;
    if (acc > hi) return hi;
    if (acc < -hi - 1) return -hi - 1;
    return acc;
  endfunction

  // four-segment jet color by body height
  function automatic logic [23:0] jet_color(longint zq);
    longint den, num, r, g, b;
    den = 45056;
    num = 10 * zq + 16384;
    if (num < 0) num = 0;
    if (num > den) num = den;
    if (4 * num < den) begin
      r = 0; g = (255 * 4 * num) / den; b = 255;
    end else if (2 * num < den) begin
      r = 0; g = 255; b = (255 * (2 * den - 4 * num)) / den;
    end else if (4 * num < 3 * den) begin
      r = (255 * (4 * num - 2 * den)) / den; g = 255; b = 0;
    end else begin
      r = 255; g = (255 * (4 * den - 4 * num)) / den; b = 0;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic point_result_t predict_point(coord_t x, coord_t y, coord_t z,
                                                  logic last);
    point_result_t res;
    longint b[3];
    logic signed [OFF_BITS-1:0] ov;
    for (int j = 0; j < 3; j++) begin
      ov = extr_off[OFF_BITS*j +: OFF_BITS];
      b[j] = rotate_row(extr_row[j], x, y, z, ov);
    end
    res.keep = b[0] > -CROP_Q12 && b[0] < CROP_Q12 && b[1] > -CROP_Q12 &&
               b[1] < CROP_Q12 && 10 * b[2] > -4096;
    res.bx = b[0]; res.by = b[1]; res.bz = b[2];
    res.color = res.keep ? jet_color(b[2]) : 24'd0;
    res.odom_valid = odom_en;
    res.ox = '0; res.oy = '0; res.oz = '0;
    if (res.keep && odom_en) begin
      res.ox = rotate_row(odom_row[0], b[0], b[1], b[2], 0);
      res.oy = rotate_row(odom_row[1], b[0], b[1], b[2], 0);
      res.oz = rotate_row(odom_row[2], b[0], b[1], b[2], 0);
    end
    res.eoc = last;
    return res;
  endfunction

  task automatic report_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    point_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual keep=%0d base=%0d,%0d,%0d",
                 $time, out_keep, out_base_x, out_base_y, out_base_z);
      end else begin
        e = pending_results.pop_front();
        report_field("keep", e.keep, out_keep);
        report_field("base_x", e.bx, out_base_x);
        report_field("base_y", e.by, out_base_y);
        report_field("base_z", e.bz, out_base_z);
        report_field("color", e.color, out_color);
        report_field("odom_valid", e.odom_valid, out_odom_valid);
        report_field("odom_x", e.ox, out_odom_x);
        report_field("odom_y", e.oy, out_odom_y);
        report_field("odom_z", e.oz, out_odom_z);
        report_field("end_of_cloud", e.eoc, out_end_of_cloud);
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EXTR_ROW0: extr_row[0] = data[ROW_BITS-1:0];
      REG_EXTR_ROW1: extr_row[1] = data[ROW_BITS-1:0];
      REG_EXTR_ROW2: extr_row[2] = data[ROW_BITS-1:0];
      REG_EXTR_OFF:  extr_off = data[OFFV_BITS-1:0];
      REG_ODOM_ROW0: odom_row[0] = data[ROW_BITS-1:0];
      REG_ODOM_ROW1: odom_row[1] = data[ROW_BITS-1:0];
      REG_ODOM_ROW2: odom_row[2] = data[ROW_BITS-1:0];
      default:       odom_en = data[0];
    endcase
    @(posedge clk);
  endtask

  function automatic row_t pack_row(longint c0, longint c1, longint c2);
    logic [COEF_BITS-1:0] a, b, c;
    a = c0; b = c1; c = c2;
    return {c, b, a};
  endfunction

  function automatic logic [OFFV_BITS-1:0] pack_off(longint o0, longint o1, longint o2);
    logic [OFF_BITS-1:0] a, b, c;
    a = o0; b = o1; c = o2;
    return {c, b, a};
  endfunction

  // send one point transaction; predict at acceptance
  task automatic send_point(longint x, longint y, longint z, logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_point(x, y, z, last));
  endtask

  // hold until every prediction has been matched, then let the pipe empty
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic longint rand_coef();
    case ($urandom_range(3))
      0: return $urandom_range(131071) - 131072 + $urandom_range(131071) + 1;
      1: return 0;
      default: return longint'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  function automatic longint rand_coord();
    case ($urandom_range(9))
      0, 1: return longint'($urandom_range(16777215)) - 8388608;
      2: return longint'($urandom_range(8192)) - 4096;
      default: return longint'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  task automatic load_random_config();
    for (int j = 0; j < 3; j++) begin
      write_reg(REG_EXTR_ROW0 + j, pack_row(rand_coef(), rand_coef(), rand_coef()));
      write_reg(REG_ODOM_ROW0 + j, pack_row(rand_coef(), rand_coef(), rand_coef()));
    end
    write_reg(REG_EXTR_OFF, pack_off(longint'($urandom_range(8192)) - 4096,
                                     longint'($urandom_range(8192)) - 4096,
                                     longint'($urandom_range(8192)) - 4096));
    write_reg(REG_ODOM_EN, $urandom_range(1));
  endtask

  task automatic load_identity(logic en);
    write_reg(REG_EXTR_ROW0, ROW0_RST);
    write_reg(REG_EXTR_ROW1, ROW1_RST);
    write_reg(REG_EXTR_ROW2, ROW2_RST);
    write_reg(REG_EXTR_OFF, '0);
    write_reg(REG_ODOM_ROW0, ROW0_RST);
    write_reg(REG_ODOM_ROW1, ROW1_RST);
    write_reg(REG_ODOM_ROW2, ROW2_RST);
    write_reg(REG_ODOM_EN, en);
  endtask

  // crop edges, color segments and coordinate extremes at reset config
  task automatic test_crop_and_color();
    send_point(0, 0, 0, 1'b0);
    send_point(12287, -12287, 100, 1'b0);
    send_point(12288, 0, 100, 1'b0);
    send_point(0, -12288, 100, 1'b0);
    send_point(0, 0, -409, 1'b0);
    send_point(0, 0, -410, 1'b0);
    send_point(0, 0, -512, 1'b0);
    send_point(0, 0, 614, 1'b0);
    send_point(0, 0, 615, 1'b0);
    send_point(0, 0, 1741, 1'b0);
    send_point(0, 0, 8191, 1'b0);
    send_point(8388607, 8388607, 8388607, 1'b1);
    send_point(-8388608, -8388608, -8388608, 1'b1);
    wait_drain();
  endtask

  // odometry rotation on and off, with an offset
  task automatic test_odometry();
    load_identity(1'b1);
    write_reg(REG_ODOM_ROW0, pack_row(0, -65536, 0));
    write_reg(REG_ODOM_ROW1, pack_row(65536, 0, 0));
    write_reg(REG_EXTR_OFF, pack_off(4096, -2048, 205));
    send_point(1000, 2000, 3000, 1'b0);
    send_point(-1000, 500, -100, 1'b1);
    send_point(20000, 0, 0, 1'b0);
    wait_drain();
    write_reg(REG_ODOM_EN, 1'b0);
    send_point(1000, 2000, 3000, 1'b1);
    wait_drain();
  endtask

  // extreme coefficients and offsets drive the sums into saturation
  task automatic test_saturation();
    write_reg(REG_EXTR_ROW0, {ROW_BITS{1'b1}});
    write_reg(REG_EXTR_ROW1, pack_row(131071, 131071, 131071));
    write_reg(REG_EXTR_ROW2, pack_row(-131072, -131072, -131072));
    write_reg(REG_EXTR_OFF, {OFFV_BITS{1'b1}});
    write_reg(REG_ODOM_ROW0, pack_row(131071, 131071, 131071));
    write_reg(REG_ODOM_ROW1, {ROW_BITS{1'b1}});
    write_reg(REG_ODOM_ROW2, pack_row(-131072, 0, 0));
    write_reg(REG_ODOM_EN, 1'b1);
    send_point(8388607, 8388607, 8388607, 1'b0);
    send_point(-8388608, -8388608, -8388608, 1'b1);
    send_point(1, -1, 0, 1'b0);
    send_point(-4000, 0, -4000, 1'b0);
    wait_drain();
    write_reg(REG_EXTR_OFF, pack_off(524287, -524288, 524287));
    send_point(0, 0, 0, 1'b0);
    wait_drain();
  endtask

  // random clouds under random configuration
  task automatic test_random_clouds(int n, int idle, int stall, bit pause_midway);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if ($urandom_range(2) == 0) load_identity($urandom_range(1));
    else load_random_config();
    for (int i = 0; i < n; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
      if (pause_midway && i == n / 2) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    extr_row[0] = ROW0_RST; extr_row[1] = ROW1_RST; extr_row[2] = ROW2_RST;
    odom_row[0] = ROW0_RST; odom_row[1] = ROW1_RST; odom_row[2] = ROW2_RST;
    extr_off = '0;
    odom_en = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_crop_and_color();
    test_odometry();
    test_saturation();
    test_random_clouds(50, 0, 0, 1'b0);
    test_random_clouds(50, 54, 0, 1'b1);
    test_random_clouds(50, 0, 54, 1'b0);
    test_random_clouds(50, 27, 27, 1'b0);
    test_random_clouds(50, 0, 0, 1'b0);
    test_random_clouds(50, 54, 0, 1'b0);
    test_random_clouds(50, 0, 54, 1'b1);
    test_random_clouds(50, 27, 27, 1'b0);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pctcc_pkg.sv
rtl/core/pctcc_front.sv
rtl/core/pctcc_queue.sv
rtl/core/pctcc_back.sv
rtl/core/point_cloud_transform_crop_colorize_core.sv
tb/tb_top.sv
